// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the servo frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int CHNUM_W = 5;
    localparam int VALUE_W = 16;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hA1;

    localparam logic KIND_CHANNEL  = 1'b0;
    localparam logic KIND_MISMATCH = 1'b1;

    typedef struct packed {
        logic              start;
        logic              clear;
        logic [BYTE_W-1:0] data;
    } crc_cmd_t;

endpackage

`default_nettype wire

// ===== sv/sfr_if.sv =====
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels for received bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_byte_if
    import sfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if
    import sfr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [CHNUM_W-1:0] channel_number;
    logic [VALUE_W-1:0] channel_value;
    logic               last_of_frame;

    modport source (output valid, output kind, output channel_number,
                    output channel_value, output last_of_frame, input ready);
    modport sink   (input valid, input kind, input channel_number,
                    input channel_value, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== sv/sfr_crc_serial.sv =====
// ----------------------------------------------------------------------------
// sfr_crc_serial
// Bit-serial CRC-16 (poly 0x1021, MSB first); one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_crc_serial
    import sfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire crc_cmd_t         cmd,
    output logic                  busy,
    output logic [CRC_W-1:0]      crc
);

    logic [CRC_W-1:0]  crc_reg,  crc_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [2:0]        cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              fb;

    always_comb
    begin
        crc_next  = crc_reg;
        data_next = data_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fb        = crc_reg[CRC_W-1] ^ data_reg[BYTE_W-1];
        if (cmd.start)
        begin
            if (cmd.clear)
            begin
                crc_next = '0;
            end
            data_next = cmd.data;
            cnt_next  = 3'd7;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next  = {crc_reg[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
            data_next = {data_reg[BYTE_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 3'd1;
            busy_next = (cnt_reg != 3'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

endmodule

`default_nettype wire

// ===== sv/sfr_word_buf.sv =====
// ----------------------------------------------------------------------------
// sfr_word_buf
// Channel word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_word_buf #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/servo_frame_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// servo_frame_receiver_crc16
// Sync hunt, frame collection with bit-serial CRC-16 check, channel emission.
// ----------------------------------------------------------------------------
//  channel     dir   payload                                       accepted on
//  byte_ch     in    rx_byte[7:0]                                  valid & ready
//  result_ch   out   kind, channel_number[4:0], channel_value[15:0],
//                    last_of_frame                                 valid & ready
//  cfg         in    cfg_data[7:0] (sync byte)                     cfg_we
//
//  A sync or channel byte starts the serial CRC unit; bytes are refused while it is busy.
//  The two CRC bytes and bytes ignored while hunting for sync bypass the CRC unit.
//  Channel results pass through a word store read, then the output register.
//  Reset restores the sync byte to 0xA1 and returns to sync hunt; no clearing pass.
//  A stalled result holds the output register; bytes are refused while results drain.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_frame_receiver_crc16
    import sfr_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    sfr_byte_if.sink               byte_ch,
    sfr_result_if.source           result_ch,
    input  wire logic              cfg_we,
    input  wire logic [BYTE_W-1:0] cfg_data
);

    localparam int PAYLOAD_BYTES = 2 * CHANNELS;
    localparam int CRC_POS       = 1 + PAYLOAD_BYTES;
    localparam int FRAME_BYTES   = CRC_POS + 2;
    localparam int PW            = $clog2(FRAME_BYTES);
    localparam int AW            = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] ST_RECV = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [PW-1:0]      pos_reg,   pos_next;
    logic [BYTE_W-1:0]  sync_reg;
    logic [BYTE_W-1:0]  crc_hi_reg, crc_hi_next;
    logic [BYTE_W-1:0]  hi_byte_reg, hi_byte_next;
    logic [AW-1:0]      ch_reg,    ch_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg,  out_kind_next;
    logic [CHNUM_W-1:0] out_num_reg,   out_num_next;
    logic [VALUE_W-1:0] out_val_reg,   out_val_next;
    logic               out_last_reg,  out_last_next;

    crc_cmd_t           crc_cmd;
    logic               crc_busy;
    logic [CRC_W-1:0]   crc_val;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [VALUE_W-1:0] rd_data;

    logic               in_beat;
    logic               slot_free;
    logic [PW-1:0]      data_idx;
    logic [AW:0]        ch_num_wide;

    assign byte_ch.ready = (state_reg == ST_RECV) && !crc_busy;
    assign in_beat       = byte_ch.valid && byte_ch.ready;
    assign slot_free     = !out_valid_reg || result_ch.ready;
    assign data_idx      = pos_reg - PW'(1);
    assign ch_num_wide   = {1'b0, ch_reg} + (AW+1)'(1);

    assign wr_addr = AW'(data_idx >> 1);
    assign wr_data = {hi_byte_reg, byte_ch.rx_byte};
    assign rd_en   = (state_reg == ST_RD);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        crc_hi_next    = crc_hi_reg;
        hi_byte_next   = hi_byte_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_kind_next  = out_kind_reg;
        out_num_next   = out_num_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        crc_cmd        = '{start: 1'b0, clear: 1'b0, data: byte_ch.rx_byte};
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_RECV:
            begin
                if (in_beat)
                begin
                    priority if (pos_reg == '0)
                    begin
                        if (byte_ch.rx_byte == sync_reg)
                        begin
                            crc_cmd.start = 1'b1;
                            crc_cmd.clear = 1'b1;
                            pos_next      = PW'(1);
                        end
                    end
                    else if (pos_reg < PW'(CRC_POS))
                    begin
                        crc_cmd.start = 1'b1;
                        pos_next      = pos_reg + PW'(1);
                        if (data_idx[0])
                        begin
                            wr_en = 1'b1;
                        end
                        else
                        begin
                            hi_byte_next = byte_ch.rx_byte;
                        end
                    end
                    else if (pos_reg == PW'(CRC_POS))
                    begin
                        crc_hi_next = byte_ch.rx_byte;
                        pos_next    = pos_reg + PW'(1);
                    end
                    else
                    begin
                        pos_next = '0;
                        ch_next  = '0;
                        if ({crc_hi_reg, byte_ch.rx_byte} == crc_val)
                        begin
                            state_next = ST_RD;
                        end
                        else
                        begin
                            state_next = ST_ERR;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_MISMATCH;
                    out_num_next   = CHNUM_W'(1);
                    out_val_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_RECV;
                end
            end
            ST_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CHANNEL;
                    out_num_next   = CHNUM_W'(ch_num_wide);
                    out_val_next   = rd_data;
                    out_last_next  = (ch_reg == AW'(CHANNELS - 1));
                    if (ch_reg == AW'(CHANNELS - 1))
                    begin
                        state_next = ST_RECV;
                    end
                    else
                    begin
                        ch_next    = ch_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RECV;
            pos_reg       <= '0;
            sync_reg      <= SYNC_RESET;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                sync_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_hi_reg   <= crc_hi_next;
        hi_byte_reg  <= hi_byte_next;
        out_kind_reg <= out_kind_next;
        out_num_reg  <= out_num_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    sfr_crc_serial u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .busy  (crc_busy),
        .crc   (crc_val)
    );

    sfr_word_buf #(
        .DEPTH (CHANNELS),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ch_reg),
        .rd_data (rd_data)
    );

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.kind           = out_kind_reg;
    assign result_ch.channel_number = out_num_reg;
    assign result_ch.channel_value  = out_val_reg;
    assign result_ch.last_of_frame  = out_last_reg;

    a_beat_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> !crc_busy)
        else $error("byte taken while CRC unit busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        crc_cmd.start |=> crc_busy)
        else $error("CRC unit did not start");

    a_drain_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RECV |-> pos_reg == '0)
        else $error("frame position not cleared while draining");

    a_mismatch_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_MISMATCH
            |-> out_last_reg && out_num_reg == CHNUM_W'(1) && out_val_reg == '0)
        else $error("malformed mismatch result");

endmodule

`default_nettype wire
